// ----- design/bmps_pkg.sv -----
package bmps_pkg;

    // Fixed field widths
    localparam int MATCH_W      = 64;
    localparam int STREAM_IDX_W = 3;

    // Parameter defaults
    localparam int DEF_WORD_BITS   = 64;
    localparam int DEF_MAX_STREAMS = 8;
    localparam int DEF_POS_BITS    = 48;

    // Register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // stream_count register
    localparam int               CNT_REG_W        = 4;
    localparam logic [CNT_REG_W-1:0] CNT_RESET    = 4'd1;
    localparam logic             REG_STREAM_COUNT = 1'b0;

endpackage

// ----- design/bmps_bitscan.sv -----
// Lowest-set-bit unit: index of the lowest set bit and the word with it cleared.
module bmps_bitscan #(
    parameter int WORD_BITS = bmps_pkg::DEF_WORD_BITS,
    localparam int IDX_W    = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] bits,
    output logic [IDX_W-1:0]     low_idx,
    output logic [WORD_BITS-1:0] rest
);

    // priority encoder, lowest index wins
    always_comb
    begin
        low_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
    end

    assign rest = bits & (bits - WORD_BITS'(1));

endmodule

// ----- design/bmps_regs.sv -----
// stream_count register with clamp to 1..MAX_STREAMS.
module bmps_regs #(
    parameter int MAX_STREAMS = bmps_pkg::DEF_MAX_STREAMS,
    localparam int CNT_W      = $clog2(MAX_STREAMS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmps_pkg::APB_AW-1:0]  paddr,
    input  logic [bmps_pkg::APB_DW-1:0]  pwdata,
    output logic [bmps_pkg::APB_DW-1:0]  prdata,
    output logic [CNT_W-1:0]             eff_count
);

    localparam int CMP_W = CNT_W + bmps_pkg::CNT_REG_W;

    logic [bmps_pkg::CNT_REG_W-1:0] count_reg;
    logic                           reg_sel;
    logic [CMP_W-1:0]               raw_ext;

    assign reg_sel = (paddr[2] == bmps_pkg::REG_STREAM_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= bmps_pkg::CNT_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            count_reg <= pwdata[bmps_pkg::CNT_REG_W-1:0];
        end
    end

    assign prdata = reg_sel ? bmps_pkg::APB_DW'(count_reg) : '0;

    assign raw_ext = CMP_W'(count_reg);

    always_comb
    begin
        priority if (raw_ext == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (raw_ext > CMP_W'(MAX_STREAMS))
        begin
            eff_count = CNT_W'(MAX_STREAMS);
        end
        else
        begin
            eff_count = raw_ext[CNT_W-1:0];
        end
    end

endmodule

// ----- design/bitmap_match_position_scanner_core.sv -----
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------
// word     | word_valid / word_stall   | match_word
// report   | report_valid / report_stall | position, stream_index, last
// config   | APB write/read            | stream_count at byte address 0
//
// An accepted request occupies the block until every set bit of its word has
// been reported; an all-zero word does not leave idle and reports nothing.
// The shared lowest-set-bit unit retires one bit per cycle; a stall on report
// holds it.
// word_stall is high while a word is being scanned, regardless of report.
// Reset (rst_n, async, active low) clears word base and stream counter and
// sets stream_count to 1; no clearing pass is needed.
module bitmap_match_position_scanner_core #(
    parameter int WORD_BITS   = bmps_pkg::DEF_WORD_BITS,
    parameter int MAX_STREAMS = bmps_pkg::DEF_MAX_STREAMS,
    parameter int POS_BITS    = bmps_pkg::DEF_POS_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               word_valid,
    output logic                               word_stall,
    input  logic [bmps_pkg::MATCH_W-1:0]       match_word,

    output logic                               report_valid,
    input  logic                               report_stall,
    output logic [POS_BITS-1:0]                position,
    output logic [bmps_pkg::STREAM_IDX_W-1:0]  stream_index,
    output logic                               last,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bmps_pkg::APB_AW-1:0]        paddr,
    input  logic [bmps_pkg::APB_DW-1:0]        pwdata,
    output logic [bmps_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int IDX_W    = $clog2(WORD_BITS);
    localparam int CNT_W    = $clog2(MAX_STREAMS + 1);
    localparam int STREAM_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CMP_W    = CNT_W + STREAM_W;
    localparam int SX_W     = STREAM_W + bmps_pkg::STREAM_IDX_W;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg, state_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [POS_BITS-1:0]  word_base_reg, word_base_next;
    logic [STREAM_W-1:0]  cur_stream_reg, cur_stream_next;
    logic [POS_BITS-1:0]  scan_base_reg, scan_base_next;
    logic [STREAM_W-1:0]  scan_stream_reg, scan_stream_next;

    logic                 rep_valid_reg, rep_valid_next;
    logic [POS_BITS-1:0]  rep_pos_reg, rep_pos_next;
    logic [STREAM_W-1:0]  rep_stream_reg, rep_stream_next;
    logic                 rep_last_reg, rep_last_next;

    logic [CNT_W-1:0]     eff_count;
    logic [IDX_W-1:0]     low_idx;
    logic [WORD_BITS-1:0] rest;
    logic [WORD_BITS-1:0] word_in;
    logic                 accept;
    logic                 out_free;
    logic [CMP_W-1:0]     stream_inc;
    logic                 group_done;
    logic [SX_W-1:0]      stream_ext;

    bmps_regs #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .eff_count (eff_count)
    );

    assign pready = 1'b1;

    // shared unit: one set bit retired per use
    bmps_bitscan #(
        .WORD_BITS (WORD_BITS)
    ) u_bitscan (
        .bits    (rem_reg),
        .low_idx (low_idx),
        .rest    (rest)
    );

    assign word_stall = (state_reg == ST_SCAN);
    assign accept     = word_valid && !word_stall;
    assign word_in    = match_word[WORD_BITS-1:0];
    assign out_free   = !rep_valid_reg || !report_stall;

    // stream counter wraps when it reaches the effective count; a count
    // shrunk mid-group wraps on the next word as well
    assign stream_inc = CMP_W'(cur_stream_reg) + CMP_W'(1);
    assign group_done = (stream_inc >= CMP_W'(eff_count));

    always_comb
    begin
        state_next       = state_reg;
        rem_next         = rem_reg;
        word_base_next   = word_base_reg;
        cur_stream_next  = cur_stream_reg;
        scan_base_next   = scan_base_reg;
        scan_stream_next = scan_stream_reg;
        rep_valid_next   = rep_valid_reg && report_stall;
        rep_pos_next     = rep_pos_reg;
        rep_stream_next  = rep_stream_reg;
        rep_last_next    = rep_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // snapshot this word's base and stream, then step counters
                    rem_next         = word_in;
                    scan_base_next   = word_base_reg;
                    scan_stream_next = cur_stream_reg;
                    if (group_done)
                    begin
                        cur_stream_next = '0;
                        word_base_next  = word_base_reg + POS_BITS'(WORD_BITS);
                    end
                    else
                    begin
                        cur_stream_next = stream_inc[STREAM_W-1:0];
                    end
                    if (word_in != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    rep_valid_next  = 1'b1;
                    rep_pos_next    = scan_base_reg + POS_BITS'(low_idx);
                    rep_stream_next = scan_stream_reg;
                    rep_last_next   = (rest == '0);
                    rem_next        = rest;
                    if (rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            word_base_reg  <= '0;
            cur_stream_reg <= '0;
            rep_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_base_reg  <= word_base_next;
            cur_stream_reg <= cur_stream_next;
            rep_valid_reg  <= rep_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg         <= rem_next;
        scan_base_reg   <= scan_base_next;
        scan_stream_reg <= scan_stream_next;
        rep_pos_reg     <= rep_pos_next;
        rep_stream_reg  <= rep_stream_next;
        rep_last_reg    <= rep_last_next;
    end

    // stream number reported in its low bits
    assign stream_ext   = SX_W'(rep_stream_reg);
    assign report_valid = rep_valid_reg;
    assign position     = rep_pos_reg;
    assign stream_index = stream_ext[bmps_pkg::STREAM_IDX_W-1:0];
    assign last         = rep_last_reg;

endmodule

// ----- design/bmps_checker.sv -----
module bmps_checker #(
    parameter int WORD_BITS = bmps_pkg::DEF_WORD_BITS,
    parameter int POS_BITS  = bmps_pkg::DEF_POS_BITS
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               word_valid,
    input logic                               word_stall,
    input logic [bmps_pkg::MATCH_W-1:0]       match_word,
    input logic                               report_valid,
    input logic                               report_stall,
    input logic [POS_BITS-1:0]                position,
    input logic [bmps_pkg::STREAM_IDX_W-1:0]  stream_index,
    input logic                               last
);

    logic word_acc;
    logic word_zero;

    assign word_acc  = word_valid && !word_stall;
    assign word_zero = (match_word[WORD_BITS-1:0] == '0);

    // stalled report holds
    a_rep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_stall |=>
            report_valid && $stable(position) && $stable(stream_index) && $stable(last))
        else $error("report changed while stalled");

    // word with set bits keeps the block busy next cycle
    a_busy_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        word_acc && !word_zero |=> word_stall)
        else $error("not busy after word with matches");

    // empty word reports nothing and frees the block at once
    a_free_after_empty: assert property (@(posedge clk) disable iff (!rst_n)
        word_acc && word_zero |=> !word_stall)
        else $error("busy after empty word");

    // a non-final report means the word is still being scanned
    a_busy_before_last: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !last |-> word_stall)
        else $error("idle with word reports still pending");

endmodule

bind bitmap_match_position_scanner_core bmps_checker #(
    .WORD_BITS (WORD_BITS),
    .POS_BITS  (POS_BITS)
) u_bmps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .match_word   (match_word),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .position     (position),
    .stream_index (stream_index),
    .last         (last)
);
